[rtl/sns_pkg.sv]
package sns_pkg;

  localparam int unsigned NOTE_SLOTS      = 5;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned PHASE_BITS      = 24;

  localparam int unsigned QUARTER_BITS = SINE_TABLE_BITS - 2;
  localparam int unsigned QUARTER_SIZE = 1 << QUARTER_BITS;

  // Note word layout: increment in the low field, duration in the high field
  localparam int unsigned INC_W  = 24;
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned WORD_W = INC_W + DUR_W;

  localparam int unsigned AMP_W    = 15;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NOTE_W   = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned INDEX_W  = 32;

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(8192);

  // Configuration map: note words first, then count and gain, 8-byte stride
  localparam int unsigned CFG_REGS   = NOTE_SLOTS + 2;
  localparam int unsigned CFG_IDX_W  = $clog2(CFG_REGS);
  localparam int unsigned CFG_ADDR_W = CFG_IDX_W + 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NOTES_IN_USE = CFG_IDX_W'(NOTE_SLOTS);
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = CFG_IDX_W'(NOTE_SLOTS + 1);

  // Odd Taylor coefficients of sin(pi/2 * x), Q30
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598669;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172273;

  typedef logic [MAG_W-1:0] rom_t [QUARTER_SIZE];

  // Evaluated at elaboration only: quarter-wave entry k in Q15, saturated
  function automatic logic [MAG_W-1:0] quarter_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] v;
    x   = 64'(k) << (30 - QUARTER_BITS);
    x2  = (x * x) >> 30;
    acc = C7 - ((x2 * C9) >> 30);
    acc = C5 - ((x2 * acc) >> 30);
    acc = C3 - ((x2 * acc) >> 30);
    acc = C1 - ((x2 * acc) >> 30);
    acc = (x * acc) >> 30;
    v   = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int unsigned i = 0; i < QUARTER_SIZE; i++) begin
      rom[i] = quarter_sine(i);
    end
    return rom;
  endfunction

endpackage

[rtl/sine_note_sequencer.sv]
// Processing: an accepted tick passes through the phase, lookup, scale and
// finish states (straight to finish when the melody is already done); the word
// is then registered on the output and held until taken. A new tick is refused
// until the word is in the output register; a single 24x24 multiplier is shared
// by the phase product and the gain product, and the block is busy while it iterates.
// Reset: asynchronous, active low; sample index, note position and note start
// clear, note words and count clear, gain returns to 0.25 full scale.
module sine_note_sequencer
  import sns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  // sample channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   sample_out_o,
  output logic [NOTE_W-1:0]     playing_note_o,
  output logic                  done_res_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned MUL_W = PHASE_BITS + INC_W;
  localparam rom_t SineRom = build_rom();
  localparam logic [MAG_W-1:0] SinePeak = quarter_sine(QUARTER_SIZE);
  localparam logic [QUARTER_BITS:0] QuarterSize = (QUARTER_BITS+1)'(QUARTER_SIZE);
  localparam logic [POS_W-1:0] SlotCount = POS_W'(NOTE_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LOOKUP,
    ST_SCALE,
    ST_FINISH
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Software writes them only while the sequencer is
  // idle (a rule for the user; the block does not enforce it); a write takes effect at the access edge.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]    note_words_q [NOTE_SLOTS];
  logic [NOTE_W-1:0]    notes_in_use_q;
  logic [AMP_W-1:0]     amp_q;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NOTE_SLOTS; i++) begin
        note_words_q[i] <= '0;
      end
      notes_in_use_q <= '0;
      amp_q          <= AMP_RESET;
    end else if (cfg_wr) begin
      for (int unsigned i = 0; i < NOTE_SLOTS; i++) begin
        if (cfg_idx == CFG_IDX_W'(i)) begin
          note_words_q[i] <= pwdata[WORD_W-1:0];
        end
      end
      if (cfg_idx == CFG_NOTES_IN_USE) begin
        notes_in_use_q <= pwdata[NOTE_W-1:0];
      end
      if (cfg_idx == CFG_AMPLITUDE) begin
        amp_q <= pwdata[AMP_W-1:0];
      end
    end
  end

  // Read back; addresses past the list read zero
  always_comb begin
    prdata = '0;
    for (int unsigned i = 0; i < NOTE_SLOTS; i++) begin
      if (cfg_idx == CFG_IDX_W'(i)) begin
        prdata = CFG_DATA_W'(note_words_q[i]);
      end
    end
    if (cfg_idx == CFG_NOTES_IN_USE) begin
      prdata = CFG_DATA_W'(notes_in_use_q);
    end
    if (cfg_idx == CFG_AMPLITUDE) begin
      prdata = CFG_DATA_W'(amp_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Tick acceptance: resolve restart, pick the note, decide the advance.
  // Melody state moves at acceptance; the sample is built from the values
  // captured here.
  // ---------------------------------------------------------------------------
  state_e               state_q;
  logic [INDEX_W-1:0]   sample_index_q;
  logic [POS_W-1:0]     note_pos_q;
  logic [INDEX_W-1:0]   note_start_q;

  logic [PHASE_BITS-1:0] sidx_lo_q;
  logic [INC_W-1:0]      inc_q;
  logic [POS_W-1:0]      shown_q;
  logic                  done_q;
  logic [MUL_W-1:0]      prod_q;
  logic [MAG_W-1:0]      mag_q;
  logic                  neg_q;

  logic                  out_valid_q;
  logic [SAMPLE_W-1:0]   sample_q;
  logic [NOTE_W-1:0]     note_out_q;
  logic                  done_out_q;

  logic                  in_accept;
  logic [POS_W-1:0]      count;
  logic [INDEX_W-1:0]    sidx_cur;
  logic [POS_W-1:0]      pos_cur;
  logic [INDEX_W-1:0]    start_cur;
  logic                  done_cur;
  logic [WORD_W-1:0]     word_cur;
  logic [INDEX_W-1:0]    elapsed;
  logic                  advance;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // A count above the slot number saturates
  assign count = (POS_W'(notes_in_use_q) > SlotCount) ? SlotCount
                                                       : POS_W'(notes_in_use_q);

  assign sidx_cur  = restart_i ? '0 : sample_index_q;
  assign pos_cur   = restart_i ? '0 : note_pos_q;
  assign start_cur = restart_i ? '0 : note_start_q;
  assign done_cur  = (pos_cur >= count);

  always_comb begin
    word_cur = '0;
    for (int unsigned i = 0; i < NOTE_SLOTS; i++) begin
      if (pos_cur == POS_W'(i)) begin
        word_cur = note_words_q[i];
      end
    end
  end

  // Elapsed count wraps with the index; a note ends once it exceeds duration
  assign elapsed = sidx_cur - start_cur;
  assign advance = !done_cur &&
                   (elapsed > INDEX_W'(word_cur[INC_W +: DUR_W]));

  // ---------------------------------------------------------------------------
  // Shared multiplier: phase = index * increment, then magnitude * gain
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] mul_a;
  logic [INC_W-1:0]      mul_b;
  logic [MUL_W-1:0]      mul_p;

  always_comb begin
    if (state_q == ST_PHASE) begin
      mul_a = sidx_lo_q;
      mul_b = inc_q;
    end else begin
      mul_a = PHASE_BITS'(mag_q);
      mul_b = INC_W'(amp_q);
    end
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // ---------------------------------------------------------------------------
  // Quarter-wave lookup with quadrant folding
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0]      phase;
  logic [SINE_TABLE_BITS-1:0] tbl_n;
  logic [1:0]                 quad;
  logic [QUARTER_BITS:0]      qidx;
  logic [MAG_W-1:0]           rom_mag;

  assign phase = prod_q[PHASE_BITS-1:0];
  assign tbl_n = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad  = tbl_n[SINE_TABLE_BITS-1 -: 2];
  assign qidx  = quad[0] ? (QuarterSize - {1'b0, tbl_n[QUARTER_BITS-1:0]})
                         : {1'b0, tbl_n[QUARTER_BITS-1:0]};
  // Only the quarter point itself sets the top bit
  assign rom_mag = qidx[QUARTER_BITS] ? SinePeak : SineRom[qidx[QUARTER_BITS-1:0]];

  // ---------------------------------------------------------------------------
  // Sample assembly: truncate the gain product, reapply sign, zero when done
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]    scaled;
  logic [SAMPLE_W-1:0] sample_d;
  logic                out_free;

  assign scaled   = prod_q[15 +: MAG_W];
  assign sample_d = done_q ? '0
                  : neg_q ? SAMPLE_W'(-{1'b0, scaled})
                          : {1'b0, scaled};
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sample_index_q <= '0;
      note_pos_q     <= '0;
      note_start_q   <= '0;
      out_valid_q    <= 1'b0;
      sidx_lo_q      <= '0;
      inc_q          <= '0;
      shown_q        <= '0;
      done_q         <= 1'b0;
      prod_q         <= '0;
      mag_q          <= '0;
      neg_q          <= 1'b0;
      sample_q       <= '0;
      note_out_q     <= '0;
      done_out_q     <= 1'b0;
    end else begin
      // drop the output word once the sink takes it, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            sidx_lo_q      <= sidx_cur[PHASE_BITS-1:0];
            inc_q          <= word_cur[INC_W-1:0];
            shown_q        <= pos_cur;
            done_q         <= done_cur;
            sample_index_q <= sidx_cur + INDEX_W'(1);
            if (advance) begin
              note_pos_q   <= pos_cur + POS_W'(1);
              note_start_q <= sidx_cur;
            end else begin
              note_pos_q   <= pos_cur;
              note_start_q <= start_cur;
            end
            state_q <= done_cur ? ST_FINISH : ST_PHASE;
          end
        end
        ST_PHASE: begin
          prod_q  <= mul_p;
          state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          mag_q   <= rom_mag;
          neg_q   <= quad[1];
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          prod_q  <= mul_p;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            sample_q    <= sample_d;
            note_out_q  <= shown_q[NOTE_W-1:0];
            done_out_q  <= done_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_q;
  assign playing_note_o = note_out_q;
  assign done_res_o     = done_out_q;

endmodule

[rtl/sns_checker.sv]
module sns_checker
  import sns_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SAMPLE_W-1:0] sample_out_o,
  input logic [NOTE_W-1:0]   playing_note_o,
  input logic                done_res_o,
  input logic                pready
);

  // A waiting word stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A finished melody yields silence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> sample_out_o == '0)
    else $error("nonzero sample after melody end");

  // A playing note is always a real slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> 32'(playing_note_o) < NOTE_SLOTS)
    else $error("playing note outside the slot range");

  // One tick at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("tick accepted while a sample is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind sine_note_sequencer sns_checker u_sns_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sample_out_o   (sample_out_o),
  .playing_note_o (playing_note_o),
  .done_res_o     (done_res_o),
  .pready         (pready)
);

[dv/sine_note_sequencer_checker.sv]
`timescale 1ns / 1ps

// Watches the tick, sample and register ports, predicts every sample word and
// compares it field by field with what the sequencer hands out.
module sine_note_sequencer_checker
  import sns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  restart_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMPLE_W-1:0]   sample_out_i,
  input  logic [NOTE_W-1:0]     playing_note_i,
  input  logic                  done_res_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [NOTE_W-1:0]   note;
    logic                done;
  } tick_word_t;

  // Q30 odd Taylor terms of sin(pi/2 * x)
  localparam logic [63:0] TAYLOR_1 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_3 = 64'd693598669;
  localparam logic [63:0] TAYLOR_5 = 64'd85569306;
  localparam logic [63:0] TAYLOR_7 = 64'd5026995;
  localparam logic [63:0] TAYLOR_9 = 64'd172273;

  logic [MAG_W-1:0]   quarter_wave [QUARTER_SIZE+1];
  logic [WORD_W-1:0]  note_word [NOTE_SLOTS];
  logic [NOTE_W-1:0]  melody_len;
  logic [AMP_W-1:0]   gain;
  logic [INDEX_W-1:0] tick_count;
  logic [INDEX_W-1:0] note_start;
  logic [NOTE_W-1:0]  note_pos;
  tick_word_t         expected_ticks [$];
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [MAG_W-1:0] sine_magnitude(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] poly;
    logic [63:0] v;
    x    = 64'(k) << (30 - QUARTER_BITS);
    x2   = (x * x) >> 30;
    poly = TAYLOR_7 - ((x2 * TAYLOR_9) >> 30);
    poly = TAYLOR_5 - ((x2 * poly) >> 30);
    poly = TAYLOR_3 - ((x2 * poly) >> 30);
    poly = TAYLOR_1 - ((x2 * poly) >> 30);
    poly = (x * poly) >> 30;
    v    = (poly * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= QUARTER_SIZE; k++) begin
      quarter_wave[k] = sine_magnitude(k);
    end
  end

  // Form the sample for one tick and advance the melody position.
  function automatic tick_word_t next_tick(logic restart);
    tick_word_t                 w;
    logic [NOTE_W-1:0]          count;
    logic [INC_W-1:0]           inc;
    logic [DUR_W-1:0]           dur;
    logic [63:0]                product;
    logic [PHASE_BITS-1:0]      phase;
    logic [SINE_TABLE_BITS-1:0] slot;
    logic [QUARTER_BITS-1:0]    k;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+AMP_W-1:0]     scaled;
    logic [SAMPLE_W-1:0]        level;
    logic [INDEX_W-1:0]         elapsed;
    count = (melody_len > NOTE_SLOTS) ? NOTE_W'(NOTE_SLOTS) : melody_len;
    if (restart) begin
      tick_count = '0;
      note_pos   = '0;
      note_start = '0;
    end
    w.note   = note_pos;
    w.done   = (note_pos >= count);
    w.sample = '0;
    if (!w.done) begin
      inc     = note_word[note_pos][INC_W-1:0];
      dur     = note_word[note_pos][WORD_W-1:INC_W];
      product = 64'(tick_count) * 64'(inc);
      phase   = product[PHASE_BITS-1:0];
      slot    = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
      k       = slot[QUARTER_BITS-1:0];
      mag     = slot[QUARTER_BITS] ? quarter_wave[QUARTER_SIZE - k] : quarter_wave[k];
      scaled  = mag * gain;
      level   = SAMPLE_W'(scaled >> 15);
      w.sample = slot[QUARTER_BITS+1] ? -level : level;
      elapsed = tick_count - note_start;
      if (elapsed > INDEX_W'(dur)) begin
        note_pos   = note_pos + 1'b1;
        note_start = tick_count;
      end
    end
    tick_count = tick_count + 1'b1;
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] register_value(logic [CFG_IDX_W-1:0] idx);
    if (idx < NOTE_SLOTS) begin
      return CFG_DATA_W'(note_word[idx]);
    end else if (idx == CFG_NOTES_IN_USE) begin
      return CFG_DATA_W'(melody_len);
    end
    return CFG_DATA_W'(gain);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t ns sample check: %s expected %0h got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tick_word_t            want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    if (!rst_ni) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        note_word[i] = '0;
      end
      melody_len = '0;
      gain       = AMP_RESET;
      tick_count = '0;
      note_start = '0;
      note_pos   = '0;
      expected_ticks.delete();
      pending_o <= 0;
    end else begin
      // Register access: mirror writes, check reads of mapped registers
      if (psel && penable && pready) begin
        reg_idx = paddr[CFG_ADDR_W-1:3];
        if (pwrite) begin
          if (reg_idx < NOTE_SLOTS) begin
            note_word[reg_idx] = pwdata[WORD_W-1:0];
          end else if (reg_idx == CFG_NOTES_IN_USE) begin
            melody_len = pwdata[NOTE_W-1:0];
          end else if (reg_idx == CFG_AMPLITUDE) begin
            gain = pwdata[AMP_W-1:0];
          end
        end else if (reg_idx < CFG_REGS) begin
          if (prdata !== register_value(reg_idx)) begin
            report_mismatch($sformatf("register %0d read", reg_idx),
                            register_value(reg_idx), prdata);
          end
        end
      end
      // Compare the outgoing word before queuing the one taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch("word with nothing expected", '0,
                          {sample_out_i, playing_note_i, done_res_i});
        end else begin
          want = expected_ticks.pop_front();
          if (sample_out_i !== want.sample) begin
            report_mismatch("sample_out", want.sample, sample_out_i);
          end
          if (playing_note_i !== want.note) begin
            report_mismatch("playing_note", want.note, playing_note_i);
          end
          if (done_res_i !== want.done) begin
            report_mismatch("done_res", want.done, done_res_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_ticks.push_back(next_tick(restart_i));
      end
      pending_o <= expected_ticks.size();
    end
  end

endmodule

[dv/sine_note_sequencer_tb.sv]
`timescale 1ns / 1ps

module sine_note_sequencer_tb;
  import sns_pkg::*;

  localparam int LATENCY       = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 75;
  localparam int CFG_UNUSED    = CFG_REGS;  // first index past the register map

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [SAMPLE_W-1:0]   sample_out_o;
  logic [NOTE_W-1:0]     playing_note_o;
  logic                  done_res_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int tx_mode = 0;   // 0: no gaps, 1: light gaps, 2: heavy gaps
  int rx_mode = 0;   // same scale for receiver stalls
  bit long_hold = 1'b0;
  int quiet;

  sine_note_sequencer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .playing_note_o (playing_note_o),
    .done_res_o     (done_res_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sine_note_sequencer_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_i   (sample_out_o),
    .playing_note_i (playing_note_o),
    .done_res_i     (done_res_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Gap length for either side: none in mode 0, else a mix of none, short and a few long
  function automatic int gap_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < (mode == 1 ? 70 : 35)) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Keep the written field, fill the unused upper bits with noise
  function automatic logic [63:0] with_noise(logic [63:0] v, int unsigned w);
    logic [63:0] mask;
    mask = (64'd1 << w) - 64'd1;
    return ({$urandom, $urandom} & ~mask) | (v & mask);
  endfunction

  // Offer one tick word after an optional gap; return at the accepting edge.
  task automatic send_tick(logic restart, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every predicted sample has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; psel stays up so writes can run back to back.
  task automatic cfg_write(int idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic cfg_read(int idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx * 8);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Read every mapped register back (the checker compares), then free the bus.
  task automatic readback();
    for (int i = 0; i < CFG_REGS; i++) begin
      cfg_read(i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fresh melody: mostly short notes so that note changes and the end come often.
  task automatic load_random_melody();
    logic [DUR_W-1:0] dur;
    logic [INC_W-1:0] inc;
    int               pick;
    // Now and then change only count and gain, leaving the position where it is
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          dur = DUR_W'($urandom_range(0, 24));
        end else if (pick == 8) begin
          dur = DUR_W'($urandom);
        end else begin
          dur = $urandom_range(0, 1) ? '1 : '0;
        end
        if ($urandom_range(0, 9) == 0) begin
          inc = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          inc = INC_W'($urandom);
        end
        cfg_write(i, with_noise({dur, inc}, WORD_W));
      end
    end
    cfg_write(int'(CFG_NOTES_IN_USE), with_noise($urandom_range(0, 1) ? NOTE_SLOTS :
                                                 $urandom_range(0, 7), NOTE_W));
    pick = $urandom_range(0, 6);
    cfg_write(int'(CFG_AMPLITUDE), with_noise(pick == 0 ? 0 : pick == 1 ? 32767 :
                                              $urandom_range(0, 32767), AMP_W));
  endtask

  // Receiver: random stalls; on request, hold off long enough to back up the block
  initial begin : sample_receiver
    bit hold;
    int len;
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        hold = (rx_mode != 0) && ($urandom_range(0, 2) == 0);
        len  = hold ? gap_len(rx_mode) : $urandom_range(1, 6);
        if (len == 0) begin
          len = 1;
        end
        out_stall_i <= hold;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on any port for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[sine_note_sequencer] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit first_restart;
    in_valid_i <= 1'b0;
    restart_i  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rst_ni     <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset melody has no notes: expect done words with a zero sample
    send_tick(1'b0, 0);
    send_tick(1'b1, 0);
    send_tick(1'b0, 2);
    drain();

    // Directed melody: extreme increments, zero and unit durations, quarter-wave
    // boundaries, a never-ending last note; count above the slot number saturates
    cfg_write(0, with_noise({24'd0, 24'hFFFFFF}, WORD_W));
    cfg_write(1, with_noise({24'd1, 24'd0}, WORD_W));
    cfg_write(2, with_noise({24'd2, 24'h400000}, WORD_W));
    cfg_write(3, with_noise({24'd3, 24'h155555}, WORD_W));
    cfg_write(4, with_noise({24'hFFFFFF, 24'h800001}, WORD_W));
    cfg_write(int'(CFG_NOTES_IN_USE), with_noise(7, NOTE_W));
    cfg_write(int'(CFG_AMPLITUDE), with_noise(32767, AMP_W));
    cfg_write(CFG_UNUSED, {$urandom, $urandom});  // past the map: must be ignored
    readback();
    send_tick(1'b1, 0);
    repeat (16) send_tick(1'b0, $urandom_range(0, 2));
    drain();

    // Lower the count below the current note without restart: block reads done
    cfg_write(int'(CFG_NOTES_IN_USE), with_noise(2, NOTE_W));
    cfg_write(int'(CFG_AMPLITUDE), with_noise(0, AMP_W));
    readback();
    send_tick(1'b0, 0);
    send_tick(1'b0, 1);
    drain();

    // Random melodies; registers only change while the block is empty
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_melody();
      readback();
      tx_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      rx_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      if (p == 3) begin
        // Receiver holds off while the sender keeps offering back to back
        tx_mode   = 0;
        long_hold = 1'b1;
      end
      first_restart = $urandom_range(0, 1);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        send_tick(j == 0 ? first_restart : ($urandom_range(0, 39) == 0), gap_len(tx_mode));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[sine_note_sequencer] OK");
    end else begin
      $display("[sine_note_sequencer] ERROR");
    end
    $finish;
  end

endmodule
